/* rtl/core/ascii_ppm_pixel_decoder_assert.svh */
// Assertion macros shared by the checker.
`ifndef ASCII_PPM_PIXEL_DECODER_ASSERT_SVH
`define ASCII_PPM_PIXEL_DECODER_ASSERT_SVH
`define APPM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define APPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/core/appd_pkg.sv */
// -----------------------------------------------------------------------------
// appd_pkg
// Shared types and constants of the ASCII P3 pixel decoder.
// -----------------------------------------------------------------------------
package appd_pkg;
  localparam int unsigned MaxSideDefault = 65535;
  localparam logic [1:0] StatusPixel  = 2'd0;
  localparam logic [1:0] StatusHeader = 2'd1;
  localparam logic [1:0] StatusError  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        last_pixel;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;      // Process the captured byte in the lexer and parser.
    logic div_step;  // One quotient bit.
    logic div_done;  // Commit the scaled colour.
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;  // The finished token is a colour that needs scaling.
    logic has_res;   // The step gave a result without scaling.
    logic res_after; // A result follows once scaling ends (blue token, or end of input).
  } stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0b || c == 8'h0c ||
           c == 8'h0d;
  endfunction
endpackage

/* rtl/core/appd_stream_if.sv */
// -----------------------------------------------------------------------------
// appd_stream_if
// Valid/ready channel carrying one payload.
// -----------------------------------------------------------------------------
interface appd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/ascii_ppm_pixel_decoder.sv */
// -----------------------------------------------------------------------------
// ascii_ppm_pixel_decoder
// Streaming decoder of plain-text P3 images into RGBA pixels.
// -----------------------------------------------------------------------------
// Bytes of the file arrive on in_ch, one per transfer; end_of_input marks the
// end of a file and carries no byte. Results leave on out_ch: a header with
// the image sides, one pixel per blue token, or one error.
// A byte that ends no colour token passes through the step and check states
// before the next byte is accepted. A whitespace byte that closes a colour token
// runs the serial scaler, one quotient bit per cycle, so such a byte also
// waits for the whole division plus, after a blue token, the result transfer. The scaler sets the rate.
// One byte is in work at a time; the next byte is accepted once the result,
// if any, has been taken.
// Reset returns the parser to expect the magic token with no image stored.
// While out_ch is stalled the result holds and no further byte is accepted.
// -----------------------------------------------------------------------------
module ascii_ppm_pixel_decoder #(
  parameter int unsigned MaxSide = appd_pkg::MaxSideDefault
) (
  input logic clk_i,
  input logic rst_ni,
  appd_stream_if.sink   in_ch,
  appd_stream_if.source out_ch
);
  appd_pkg::ctrl_t    ctrl;
  appd_pkg::stat_t    stat;
  appd_pkg::in_item_t item_q;
  logic               capture;

  always_ff @(posedge clk_i) begin
    if (capture) item_q <= in_ch.payload;
  end

  appd_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .stat_i(stat), .ctrl_o(ctrl), .capture_o(capture)
  );

  appd_datapath #(.MaxSide(MaxSide)) u_dp (
    .clk_i, .rst_ni, .item_i(item_q), .ctrl_i(ctrl), .stat_o(stat),
    .res_o(out_ch.payload)
  );
endmodule

/* rtl/core/appd_datapath.sv */
// -----------------------------------------------------------------------------
// appd_datapath
// Lexer, token parser, header registers and the serial colour scaler.
// -----------------------------------------------------------------------------
module appd_datapath #(
  parameter int unsigned MaxSide = appd_pkg::MaxSideDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  appd_pkg::in_item_t  item_i,
  input  appd_pkg::ctrl_t     ctrl_i,
  output appd_pkg::stat_t     stat_o,
  output appd_pkg::out_item_t res_o
);
  typedef enum logic [2:0] {
    PhMagic, PhWidth, PhHeight, PhMaxv, PhRed, PhGreen, PhBlue, PhIdle
  } phase_e;
  typedef enum logic [1:0] {LxBetween, LxToken, LxComment} lexer_e;

  phase_e      phase_q, phase_d;
  lexer_e      lex_q, lex_d;
  logic [1:0]  len_q, len_d;
  logic        magic_q, magic_d, neg_q, neg_d, digits_q, digits_d;
  logic        ended_q, ended_d, ovf_q, ovf_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] width_q, width_d, height_q, height_d;
  logic [30:0] maxv_q, maxv_d;
  logic [7:0]  red_q, red_d, green_q, green_d;
  logic [31:0] left_q, left_d;
  appd_pkg::out_item_t res_q, res_d;
  logic        res_v_d, need_div_d, res_after_d;
  // Scaler: restoring division of mag*255 by max value.
  logic [39:0] num_q, num_d;
  logic [31:0] rem_q, rem_d;
  logic [8:0]  quo_q, quo_d;
  logic        dneg_q, dneg_d;

  logic [7:0]  c;
  logic [35:0] nacc;
  logic [32:0] trial;
  logic [7:0]  scaled;

  assign c = item_i.data_byte;
  assign nacc = {4'd0, acc_q} * 36'd10 + {28'd0, c - 8'h30};
  assign trial = {rem_q, num_q[39]} - {2'd0, maxv_q};
  assign scaled = dneg_q ? 8'd0 : (quo_q[8] ? 8'hff : quo_q[7:0]);

  always_comb begin
    logic        fin, tok_valid, positive;
    logic [31:0] mag;
    phase_d = phase_q; lex_d = lex_q; len_d = len_q; magic_d = magic_q;
    neg_d = neg_q; digits_d = digits_q; ended_d = ended_q; ovf_d = ovf_q;
    acc_d = acc_q; width_d = width_q; height_d = height_q; maxv_d = maxv_q;
    red_d = red_q; green_d = green_q; left_d = left_q; res_d = res_q;
    num_d = num_q; rem_d = rem_q; quo_d = quo_q; dneg_d = dneg_q;
    res_v_d = 1'b0; need_div_d = 1'b0; res_after_d = 1'b0;
    fin = 1'b0;
    mag = acc_q;
    tok_valid = digits_q && !ovf_q && (neg_q || !acc_q[31]);
    positive = !neg_q && acc_q != 32'd0;
    if (ctrl_i.step) begin
      if (item_i.end_of_input) begin
        fin = lex_q == LxToken && phase_q != PhIdle;
      end else if (phase_q != PhIdle) begin
        if (lex_q == LxToken) begin
          fin = appd_pkg::is_space(c);
        end else if (lex_q == LxComment) begin
          if (c == 8'h0a) lex_d = LxBetween;
        end else if (!appd_pkg::is_space(c) && c == 8'h23) begin
          lex_d = LxComment;
        end
        if ((lex_q == LxToken && !appd_pkg::is_space(c)) ||
            (lex_q == LxBetween && !appd_pkg::is_space(c) && c != 8'h23)) begin
          lex_d = LxToken;
          if ((len_q == 2'd0 && c != 8'h50) || (len_q == 2'd1 && c != 8'h33) ||
              len_q[1]) magic_d = 1'b0;
          if (!ended_q) begin
            if (c >= 8'h30 && c <= 8'h39) begin
              digits_d = 1'b1;
              if (!ovf_q) begin
                if (nacc > 36'h80000000) ovf_d = 1'b1;
                else acc_d = nacc[31:0];
              end
            end else if (len_q == 2'd0 && (c == 8'h2b || c == 8'h2d)) begin
              neg_d = c == 8'h2d;
            end else begin
              ended_d = 1'b1;
            end
          end
          if (len_q != 2'd3) len_d = len_q + 2'd1;
        end
      end
      if (fin) begin
        res_d = '0;
        res_d.status = appd_pkg::StatusError;
        if (phase_q == PhMagic) begin
          if (magic_q && len_q == 2'd2) phase_d = PhWidth;
          else begin phase_d = PhIdle; res_v_d = 1'b1; end
        end else if (!tok_valid) begin
          phase_d = PhIdle; res_v_d = 1'b1;
        end else if (phase_q == PhWidth || phase_q == PhHeight) begin
          if (!positive || mag > 32'(MaxSide)) begin
            phase_d = PhIdle; res_v_d = 1'b1;
          end else if (phase_q == PhWidth) begin
            width_d = mag[15:0]; phase_d = PhHeight;
          end else begin
            height_d = mag[15:0]; phase_d = PhMaxv;
          end
        end else if (phase_q == PhMaxv) begin
          if (!positive) begin
            phase_d = PhIdle; res_v_d = 1'b1;
          end else begin
            maxv_d = mag[30:0];
            left_d = {16'd0, width_q} * {16'd0, height_q};
            res_d.status = appd_pkg::StatusHeader;
            res_d.image_width = width_q;
            res_d.image_height = height_q;
            res_v_d = 1'b1;
            phase_d = PhRed;
          end
        end else begin
          need_div_d = 1'b1;
          res_after_d = phase_q == PhBlue;
          dneg_d = neg_q;
          num_d = {8'd0, mag} * 40'd255;
          rem_d = '0; quo_d = '0;
        end
        lex_d = LxBetween; len_d = '0; magic_d = 1'b1; neg_d = 1'b0;
        digits_d = 1'b0; ended_d = 1'b0; ovf_d = 1'b0; acc_d = '0;
      end
      if (item_i.end_of_input && !need_div_d) begin
        if (phase_d != PhIdle) begin
          res_d = '0; res_d.status = appd_pkg::StatusError; res_v_d = 1'b1;
        end
        phase_d = PhMagic; lex_d = LxBetween; width_d = '0; height_d = '0;
        maxv_d = '0; red_d = '0; green_d = '0; left_d = '0;
      end
    end
    if (ctrl_i.div_step) begin
      rem_d = trial[32] ? {rem_q[30:0], num_q[39]} : trial[31:0];
      quo_d = {quo_q[7:0], ~trial[32]} | {quo_q[8], 8'd0};
      num_d = {num_q[38:0], 1'b0};
    end
    if (ctrl_i.div_done) begin
      if (phase_q == PhRed) begin
        red_d = scaled; phase_d = PhGreen;
      end else if (phase_q == PhGreen) begin
        green_d = scaled; phase_d = PhBlue;
      end else begin
        left_d = left_q - 32'd1;
        res_d = '0;
        res_d.status = appd_pkg::StatusPixel;
        res_d.red = red_q; res_d.green = green_q; res_d.blue = scaled;
        res_d.alpha = 8'hff;
        res_d.last_pixel = left_q == 32'd1;
        phase_d = left_q == 32'd1 ? PhIdle : PhRed;
      end
      if (item_i.end_of_input) begin
        if (phase_d != PhIdle) begin
          res_d = '0; res_d.status = appd_pkg::StatusError;
        end
        phase_d = PhMagic; lex_d = LxBetween; width_d = '0; height_d = '0;
        maxv_d = '0; red_d = '0; green_d = '0; left_d = '0;
      end
    end
  end

  // Quotient saturates at bit 8 once any high bit appears.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhMagic; lex_q <= LxBetween; len_q <= '0; magic_q <= 1'b1;
      neg_q <= 1'b0; digits_q <= 1'b0; ended_q <= 1'b0; ovf_q <= 1'b0;
      acc_q <= '0; width_q <= '0; height_q <= '0; maxv_q <= '0;
      red_q <= '0; green_q <= '0; left_q <= '0;
      stat_o <= '0;
    end else begin
      phase_q <= phase_d; lex_q <= lex_d; len_q <= len_d; magic_q <= magic_d;
      neg_q <= neg_d; digits_q <= digits_d; ended_q <= ended_d; ovf_q <= ovf_d;
      acc_q <= acc_d; width_q <= width_d; height_q <= height_d; maxv_q <= maxv_d;
      red_q <= red_d; green_q <= green_d; left_q <= left_d;
      stat_o.need_div <= need_div_d;
      stat_o.has_res <= res_v_d;
      stat_o.res_after <= res_after_d || (need_div_d && item_i.end_of_input);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d; num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d; dneg_q <= dneg_d;
  end

  assign res_o = res_q;
endmodule

/* rtl/core/appd_controller.sv */
// -----------------------------------------------------------------------------
// appd_controller
// Sequences byte capture, the parse step, scaling and the result handshake.
// -----------------------------------------------------------------------------
module appd_controller (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  appd_pkg::stat_t stat_i,
  output appd_pkg::ctrl_t ctrl_o,
  output logic            capture_o
);
  typedef enum logic [2:0] {StIdle, StStep, StCheck, StDiv, StDone, StOut} state_e;

  state_e     state_q;
  logic [5:0] cnt_q;
  logic       after_q;

  assign in_ready_o = state_q == StIdle;
  assign capture_o = in_ready_o && in_valid_i;
  assign out_valid_o = state_q == StOut;
  always_comb begin
    ctrl_o = '0;
    ctrl_o.step = state_q == StStep;
    ctrl_o.div_step = state_q == StDiv;
    ctrl_o.div_done = state_q == StDone;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0; after_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: if (in_valid_i) state_q <= StStep;
        StStep: state_q <= StCheck;
        StCheck: begin
          cnt_q <= '0;
          after_q <= stat_i.res_after;
          if (stat_i.need_div) state_q <= StDiv;
          else if (stat_i.has_res) state_q <= StOut;
          else state_q <= StIdle;
        end
        StDiv: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd39) state_q <= StDone;
        end
        StDone: state_q <= after_q ? StOut : StIdle;
        StOut: if (out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

/* rtl/core/appd_checker.sv */
// -----------------------------------------------------------------------------
// appd_checker
// Port-level checks of the decoder.
// -----------------------------------------------------------------------------
`include "ascii_ppm_pixel_decoder_assert.svh"
module appd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input appd_pkg::out_item_t out_payload
);
  logic hold_out, known_status, is_pixel;

  assign hold_out = out_valid && !out_ready;
  assign known_status = out_payload.status == appd_pkg::StatusPixel ||
                        out_payload.status == appd_pkg::StatusHeader ||
                        out_payload.status == appd_pkg::StatusError;
  assign is_pixel = out_valid && out_payload.status == appd_pkg::StatusPixel;

  `APPM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, hold_out, out_valid && $stable(out_payload))
  `APPM_ASSERT_IMPL(a_no_accept_while_out, clk_i, rst_ni, out_valid, !in_ready)
  `APPM_ASSERT_IMPL(a_status_code, clk_i, rst_ni, out_valid, known_status)
  `APPM_ASSERT_IMPL(a_alpha, clk_i, rst_ni, is_pixel, out_payload.alpha == 8'hff)
endmodule

bind ascii_ppm_pixel_decoder appd_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
